// ===== hdl/asidst_pkg.sv =====
// Shared constants and types for the ASID allocator with round-robin steal.
// No dependencies; imported by the scan unit, the owner table and the top level.
`timescale 1ns / 1ps

package asidst_pkg;

  localparam int NUM_ENTRIES = 256;
  localparam int FIRST_ENTRY = 2;
  localparam int OWNER_BITS  = 16;

  localparam int ASID_W     = 8;
  localparam int OWNER_ID_W = 16;
  localparam int ADDR_W     = $clog2(NUM_ENTRIES);

  localparam int GRP_W       = 16;
  localparam int NUM_GROUPS  = (NUM_ENTRIES + GRP_W - 1) / GRP_W;
  localparam int GRP_IDX_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int PAD_ENTRIES = NUM_GROUPS * GRP_W;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef logic [OWNER_BITS-1:0] owner_t;

  typedef struct packed {
    logic              hit;
    logic [ASID_W-1:0] asid;
  } scan_res_t;

endpackage

// ===== hdl/asidst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module asidst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/asidst_scan.sv =====
// Free-entry search unit: priority encoder over one group of availability bits.
// Depends on asidst_pkg.
`timescale 1ns / 1ps

module asidst_scan (
  input  logic [asidst_pkg::PAD_ENTRIES-1:0] avail,
  input  logic [asidst_pkg::GRP_IDX_W-1:0]   grp,
  output asidst_pkg::scan_res_t              res
);
  import asidst_pkg::*;

  logic [GRP_W-1:0]         slice;
  logic [$clog2(GRP_W)-1:0] off;

  assign slice = avail[grp*GRP_W +: GRP_W];

  always_comb begin
    off = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (slice[i]) begin
        off = ($clog2(GRP_W))'(i);
      end
    end
  end

  assign res.hit  = |slice;
  assign res.asid = ASID_W'(GRP_W * int'(grp) + int'(off));

endmodule

// ===== hdl/asidst_ram_wrap_note.sv =====
// Owner table storage: one owner per identifier, backed by the generic RAM.
// Depends on asidst_pkg and asidst_ram.
`timescale 1ns / 1ps

module asidst_owner_table (
  input  logic                         clk,
  input  logic                         we,
  input  logic [asidst_pkg::ADDR_W-1:0] waddr,
  input  asidst_pkg::owner_t           wdata,
  input  logic [asidst_pkg::ADDR_W-1:0] raddr,
  input  logic                         rd_used,
  output asidst_pkg::owner_t           evicted
);
  import asidst_pkg::*;

  owner_t rdata;

  asidst_ram #(
    .WIDTH(OWNER_BITS),
    .DEPTH(NUM_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // unused entries read as zero owner
  assign evicted = rd_used ? rdata : '0;

endmodule

// ===== hdl/asid_allocator_with_steal_core.sv =====
// ASID allocator with round-robin steal: top level, sequencer and used bits.
// Depends on asidst_pkg, asidst_scan, asidst_owner_table.
//
//  channel | ports                                          | dir
//  in      | in_valid/in_ready, in_operation, in_owner_id,  | in
//          | in_held_asid, in_held_valid                    |
//  out     | out_valid/out_ready, out_granted_asid,         | out
//          | out_evicted_valid, out_evicted_owner,          |
//          | out_flush_request                              |
//
// Release: the result is registered straight from idle. Allocate: the used bits
// are scanned in groups of 16 by the shared priority encoder (up to 16 groups);
// a steal adds the ST_STEAL state for the owner table read.
// Reset clears all used bits at once and sets the steal pointer to the first entry.
// One item at a time: in_ready is high only when idle with the output register empty.
`timescale 1ns / 1ps

module asid_allocator_with_steal_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [asidst_pkg::OWNER_ID_W-1:0] in_owner_id,
  input  logic [asidst_pkg::ASID_W-1:0]     in_held_asid,
  input  logic                              in_held_valid,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [asidst_pkg::ASID_W-1:0]     out_granted_asid,
  output logic                              out_evicted_valid,
  output logic [asidst_pkg::OWNER_ID_W-1:0] out_evicted_owner,
  output logic                              out_flush_request
);
  import asidst_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_STEAL = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [GRP_IDX_W-1:0]   grp_r, grp_nxt;
  logic [ASID_W-1:0]      ptr_r, ptr_nxt;
  logic [NUM_ENTRIES-1:0] used_r, used_nxt;
  owner_t                 owner_r, owner_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [ASID_W-1:0]      granted_r, granted_nxt;
  logic                   ev_valid_r, ev_valid_nxt;
  owner_t                 ev_owner_r, ev_owner_nxt;
  logic                   flush_r, flush_nxt;

  logic [PAD_ENTRIES-1:0] avail;
  scan_res_t              scan_res;
  logic [ASID_W:0]        ptr_inc;
  logic [ASID_W-1:0]      ptr_wrap;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [ADDR_W-1:0]      ram_raddr;
  owner_t                 evicted;
  logic                   in_acc;
  logic                   held_in_table;

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    avail = '0;
    for (int i = FIRST_ENTRY; i < NUM_ENTRIES; i++) begin
      avail[i] = !used_r[i];
    end
  end

  asidst_scan u_scan (
    .avail(avail),
    .grp  (grp_r),
    .res  (scan_res)
  );

  assign ptr_inc  = {1'b0, ptr_r} + (ASID_W+1)'(1);
  assign ptr_wrap = (ptr_inc >= (ASID_W+1)'(NUM_ENTRIES)) ? ASID_W'(FIRST_ENTRY)
                                                           : ptr_inc[ASID_W-1:0];
  assign held_in_table = {1'b0, in_held_asid} < (ASID_W+1)'(NUM_ENTRIES);

  assign ram_raddr = ptr_wrap[ADDR_W-1:0];

  asidst_owner_table u_table (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (owner_r),
    .raddr  (ram_raddr),
    .rd_used(used_r[ptr_r[ADDR_W-1:0]]),
    .evicted(evicted)
  );

  always_comb begin
    state_nxt     = state_r;
    grp_nxt       = grp_r;
    ptr_nxt       = ptr_r;
    used_nxt      = used_r;
    owner_nxt     = owner_r;
    out_valid_nxt = out_valid_r;
    granted_nxt   = granted_r;
    ev_valid_nxt  = ev_valid_r;
    ev_owner_nxt  = ev_owner_r;
    flush_nxt     = flush_r;
    ram_we        = 1'b0;
    ram_waddr     = scan_res.asid[ADDR_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          owner_nxt = owner_t'(in_owner_id);
          if (in_operation == OP_RELEASE) begin
            if (in_held_valid && held_in_table) begin
              used_nxt[in_held_asid[ADDR_W-1:0]] = 1'b0;
            end
            out_valid_nxt = 1'b1;
            granted_nxt   = '0;
            ev_valid_nxt  = 1'b0;
            ev_owner_nxt  = '0;
            flush_nxt     = in_held_valid;
          end else begin
            grp_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_res.hit) begin
          ram_we        = 1'b1;
          used_nxt[scan_res.asid[ADDR_W-1:0]] = 1'b1;
          out_valid_nxt = 1'b1;
          granted_nxt   = scan_res.asid;
          ev_valid_nxt  = 1'b0;
          ev_owner_nxt  = '0;
          flush_nxt     = 1'b0;
          state_nxt     = ST_IDLE;
        end else if (grp_r == GRP_IDX_W'(NUM_GROUPS - 1)) begin
          // no free entry: advance pointer, read the victim's owner
          ptr_nxt   = ptr_wrap;
          state_nxt = ST_STEAL;
        end else begin
          grp_nxt = grp_r + GRP_IDX_W'(1);
        end
      end
      ST_STEAL: begin
        ram_we        = 1'b1;
        ram_waddr     = ptr_r[ADDR_W-1:0];
        used_nxt[ptr_r[ADDR_W-1:0]] = 1'b1;
        out_valid_nxt = 1'b1;
        granted_nxt   = ptr_r;
        ev_valid_nxt  = used_r[ptr_r[ADDR_W-1:0]];
        ev_owner_nxt  = evicted;
        flush_nxt     = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      grp_r       <= '0;
      ptr_r       <= ASID_W'(FIRST_ENTRY);
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grp_r       <= grp_nxt;
      ptr_r       <= ptr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    owner_r    <= owner_nxt;
    granted_r  <= granted_nxt;
    ev_valid_r <= ev_valid_nxt;
    ev_owner_r <= ev_owner_nxt;
    flush_r    <= flush_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_asid  = granted_r;
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_owner = OWNER_ID_W'(ev_owner_r);
  assign out_flush_request = flush_r;

  a_evict_flush : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ev_valid_r |-> flush_r)
    else $error("eviction reported without flush");

  a_steal_full : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEAL) |-> (avail == '0))
    else $error("steal while a free entry exists");

  a_ptr_range : assert property (@(posedge clk) disable iff (!rst_n)
    (ptr_r >= ASID_W'(FIRST_ENTRY)) && ({1'b0, ptr_r} < (ASID_W+1)'(NUM_ENTRIES)))
    else $error("steal pointer out of range");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != ST_IDLE) || out_valid_r)
    else $error("accepted item produced no work");

  a_grant_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (granted_r != '0) |->
      (granted_r >= ASID_W'(FIRST_ENTRY)) && used_r[granted_r[ADDR_W-1:0]])
    else $error("granted identifier reserved or not marked used");

endmodule
